// ===== rtl/phl_pkg.sv =====
package phl_pkg;

    // Fraction bits of a unit vector component.
    localparam int UNIT_FRAC_BITS = 14;

    // Input component and magnitude widths.
    localparam int IN_W   = 16;
    localparam int M2_W   = 2 * IN_W;
    // The magnitude is taken in Q.8, so the radicand gets 16 extra bits.
    localparam int MAG_FRAC = 8;
    localparam int RAD_PAD  = 2 * MAG_FRAC;
    localparam int RAD_W    = M2_W + RAD_PAD;
    localparam int SQ_W     = RAD_W / 2;
    localparam int REM_W    = SQ_W + 2;

    // Division of a scaled component by the magnitude.
    localparam int DIV_SH = UNIT_FRAC_BITS + MAG_FRAC;
    localparam int DVD_W  = IN_W + DIV_SH;
    localparam int Q_W    = UNIT_FRAC_BITS + 1;
    localparam int U_W    = UNIT_FRAC_BITS + 2;

    // Dot product and reflection widths.
    localparam int NL_W = UNIT_FRAC_BITS + 3;
    localparam int R_W  = UNIT_FRAC_BITS + 4;

    localparam logic [Q_W-1:0] UNIT_ONE = Q_W'(1) << UNIT_FRAC_BITS;

    // Specular exponent.
    localparam int EXP_W   = 5;
    localparam int EXP_MAX = 16;
    localparam int POW_N   = EXP_MAX - 1;

    // Pipeline latencies.
    localparam int NORM_LAT  = SQ_W + Q_W + 3;
    localparam int SHADE_LAT = 6 + POW_N + 3;
    localparam int TOT_LAT   = NORM_LAT + SHADE_LAT;

    // Color channels.
    localparam int CH_W = 8;
    localparam logic [CH_W-1:0] CH_MAX = '1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_COLOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_COLOR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_DIRECTION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIRECTION  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_REFLECT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE_REFLECT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_REFLECT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_EXPONENT   = 3'd7;
    localparam logic [EXP_W-1:0] EXP_RESET = 5'd4;

    typedef logic signed [IN_W-1:0] t_comp;
    typedef t_comp t_ivec [3];
    typedef logic signed [U_W-1:0] t_unit;
    typedef t_unit t_uvec [3];
    typedef logic [2:0][CH_W-1:0] t_rgb;

    typedef struct packed {
        logic [23:0]      ambient_color;
        logic [23:0]      light_color;
        logic [47:0]      light_direction;
        logic [47:0]      view_direction;
        logic [23:0]      ambient_reflect;
        logic [23:0]      diffuse_reflect;
        logic [23:0]      specular_reflect;
        logic [EXP_W-1:0] specular_exponent;
    } t_cfg;

endpackage

// ===== rtl/phl_in_if.sv =====
interface phl_in_if import phl_pkg::*; ();
    logic  valid;
    logic  ready;
    t_comp normal_x;
    t_comp normal_y;
    t_comp normal_z;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    input ready);
    modport sink (input valid, input normal_x, input normal_y, input normal_z,
                  output ready);
endinterface

// ===== rtl/phl_out_if.sv =====
interface phl_out_if import phl_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  output ready);
endinterface

// ===== rtl/phl_norm.sv =====
module phl_norm import phl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_ivec i_vec,
    output t_uvec o_unit
);

    localparam int NS = SQ_W + Q_W + 2;

    typedef struct packed {
        logic [2:0][IN_W-1:0] mag;
        logic [2:0]           sgn;
        logic                 nz;
    } t_side;

    // Side information that travels with the item.
    t_side r_side [NS];
    t_side n_side0;

    logic [M2_W-1:0]  r_sq [3];
    logic [RAD_W-1:0] r_rad;

    logic [REM_W-1:0] r_rem  [SQ_W];
    logic [SQ_W-1:0]  r_root [SQ_W];
    logic [RAD_W-1:0] r_rads [SQ_W];
    logic [REM_W-1:0] n_rem  [SQ_W];
    logic [SQ_W-1:0]  n_root [SQ_W];
    logic [RAD_W-1:0] n_rads [SQ_W];

    logic [DVD_W-1:0] r_dr [Q_W][3];
    logic [Q_W-1:0]   r_q  [Q_W][3];
    logic [SQ_W-1:0]  r_dm [Q_W];
    logic [DVD_W-1:0] n_dr [Q_W][3];
    logic [Q_W-1:0]   n_q  [Q_W][3];
    logic [SQ_W-1:0]  n_dm [Q_W];

    t_uvec r_unit;

    // Magnitudes and signs of the components.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_side0.sgn[k] = i_vec[k][IN_W-1];
            n_side0.mag[k] = i_vec[k][IN_W-1] ? IN_W'(-i_vec[k]) : IN_W'(i_vec[k]);
        end
        n_side0.nz = (i_vec[0] != '0) || (i_vec[1] != '0) || (i_vec[2] != '0);
    end

    // Square root, one result bit per stage.
    always_comb begin
        logic [REM_W-1:0] src_rem;
        logic [SQ_W-1:0]  src_root;
        logic [RAD_W-1:0] src_rad;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        for (int j = 0; j < SQ_W; j++) begin
            if (j == 0) begin
                src_rem  = '0;
                src_root = '0;
                src_rad  = r_rad;
            end else begin
                src_rem  = r_rem[j-1];
                src_root = r_root[j-1];
                src_rad  = r_rads[j-1];
            end
            rem2  = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
            trial = {src_root, 2'b01};
            if (rem2 >= trial) begin
                n_rem[j]  = rem2 - trial;
                n_root[j] = {src_root[SQ_W-2:0], 1'b1};
            end else begin
                n_rem[j]  = rem2;
                n_root[j] = {src_root[SQ_W-2:0], 1'b0};
            end
            n_rads[j] = src_rad << 2;
        end
    end

    // Restoring division, one quotient bit per stage for all three components.
    always_comb begin
        logic [DVD_W-1:0] src_dr [3];
        logic [Q_W-1:0]   src_q  [3];
        logic [SQ_W-1:0]  src_m;
        logic [DVD_W:0]   trial;
        for (int i = 0; i < Q_W; i++) begin
            if (i == 0) begin
                src_m = r_root[SQ_W-1];
                for (int k = 0; k < 3; k++) begin
                    src_dr[k] = DVD_W'(r_side[SQ_W+1].mag[k]) << DIV_SH;
                    src_q[k]  = '0;
                end
            end else begin
                src_m = r_dm[i-1];
                for (int k = 0; k < 3; k++) begin
                    src_dr[k] = r_dr[i-1][k];
                    src_q[k]  = r_q[i-1][k];
                end
            end
            trial   = (DVD_W+1)'(src_m) << (Q_W - 1 - i);
            n_dm[i] = src_m;
            for (int k = 0; k < 3; k++) begin
                if ({1'b0, src_dr[k]} >= trial) begin
                    n_dr[i][k] = src_dr[k] - DVD_W'(trial);
                    n_q[i][k]  = src_q[k] | (Q_W'(1) << (Q_W - 1 - i));
                end else begin
                    n_dr[i][k] = src_dr[k];
                    n_q[i][k]  = src_q[k];
                end
            end
        end
    end

    // Pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= n_side0;
            for (int g = 1; g < NS; g++) begin
                r_side[g] <= r_side[g-1];
            end
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= M2_W'(n_side0.mag[k]) * M2_W'(n_side0.mag[k]);
            end
            r_rad <= {r_sq[0] + r_sq[1] + r_sq[2], {RAD_PAD{1'b0}}};
            for (int j = 0; j < SQ_W; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_rads[j] <= n_rads[j];
            end
            for (int i = 0; i < Q_W; i++) begin
                r_dm[i] <= n_dm[i];
                for (int k = 0; k < 3; k++) begin
                    r_dr[i][k] <= n_dr[i][k];
                    r_q[i][k]  <= n_q[i][k];
                end
            end
            // Saturate, apply the sign, and force a zero vector to zero.
            for (int k = 0; k < 3; k++) begin
                if (!r_side[NS-1].nz) begin
                    r_unit[k] <= '0;
                end else if (r_side[NS-1].sgn[k]) begin
                    r_unit[k] <= -$signed(U_W'((r_q[Q_W-1][k] > UNIT_ONE) ?
                                               UNIT_ONE : r_q[Q_W-1][k]));
                end else begin
                    r_unit[k] <= $signed(U_W'((r_q[Q_W-1][k] > UNIT_ONE) ?
                                              UNIT_ONE : r_q[Q_W-1][k]));
                end
            end
        end
    end

    assign o_unit = r_unit;

endmodule

// ===== rtl/phl_shade.sv =====
module phl_shade import phl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_uvec i_n,
    input  t_uvec i_l,
    input  t_uvec i_v,
    input  logic  i_nz,
    input  t_cfg  i_cfg,
    output t_rgb  o_rgb
);

    localparam int PNL_W = 2 * U_W;
    localparam int SNL_W = PNL_W + 2;
    localparam int PRN_W = NL_W + U_W;
    localparam int PRV_W = R_W + U_W;
    localparam int SRV_W = PRV_W + 2;
    localparam int CP_W  = 2 * CH_W;
    localparam int TP_W  = CP_W + Q_W;

    // Stage A: N.L products.
    logic signed [PNL_W-1:0] r_a_pnl [3];
    t_uvec r_a_n, r_a_l, r_a_v;
    logic  r_a_nz;

    // Stage B: N.L and the diffuse factor.
    logic signed [NL_W-1:0] r_b_nl;
    logic [Q_W-1:0]         r_b_dp;
    t_uvec r_b_n, r_b_l, r_b_v;
    logic  r_b_nz;
    logic signed [SNL_W-1:0] n_b_sum;
    logic signed [SNL_W-1:0] n_b_tr;
    logic [SNL_W-1:0]        n_b_mag;

    // Stage C: (N.L) * N products.
    logic signed [PRN_W-1:0] r_c_prn [3];
    t_uvec r_c_l, r_c_v;
    logic [Q_W-1:0] r_c_dp;
    logic           r_c_nz;

    // Stage D: reflected vector.
    logic signed [R_W-1:0] r_d_r [3];
    logic signed [R_W-1:0] n_d_r [3];
    t_uvec r_d_v;
    logic [Q_W-1:0] r_d_dp;
    logic           r_d_nz;

    // Stage E: R.V products.
    logic signed [PRV_W-1:0] r_e_prv [3];
    logic [Q_W-1:0] r_e_dp;
    logic           r_e_nz;

    // Stage F: the specular factor.
    logic [Q_W-1:0] r_f_sp;
    logic [Q_W-1:0] r_f_dp;
    logic signed [SRV_W-1:0] n_f_sum;
    logic signed [SRV_W-1:0] n_f_tr;
    logic [SRV_W-1:0]        n_f_mag;

    // Power stages.
    logic [Q_W-1:0] r_p   [POW_N];
    logic [Q_W-1:0] r_psp [POW_N];
    logic [Q_W-1:0] r_pdp [POW_N];
    logic [Q_W-1:0] n_p   [POW_N];
    logic [EXP_W-1:0] exp_eff;

    // Term stages.
    logic [CP_W-1:0] r_t0_a [3];
    logic [CP_W-1:0] r_t0_d [3];
    logic [CP_W-1:0] r_t0_s [3];
    logic [Q_W-1:0]  r_t0_dp;
    logic [Q_W-1:0]  r_t0_p;
    logic [CH_W-1:0] r_t1_a [3];
    logic [CH_W-1:0] r_t1_d [3];
    logic [CH_W-1:0] r_t1_s [3];
    logic [TP_W-1:0] n_t1_d [3];
    logic [TP_W-1:0] n_t1_s [3];
    logic [CH_W+1:0] n_t2_sum [3];
    t_rgb r_rgb;

    // N.L, truncated toward zero.
    always_comb begin
        n_b_sum = SNL_W'(r_a_pnl[0]) + SNL_W'(r_a_pnl[1]) + SNL_W'(r_a_pnl[2]);
        n_b_mag = n_b_sum[SNL_W-1] ? SNL_W'(-n_b_sum) : SNL_W'(n_b_sum);
        n_b_tr  = n_b_sum[SNL_W-1] ? -$signed(n_b_mag >> UNIT_FRAC_BITS)
                                   : $signed(n_b_mag >> UNIT_FRAC_BITS);
    end

    // R = trunc(2 (N.L) N) - L.
    always_comb begin
        logic signed [PRN_W:0] x;
        logic [PRN_W:0]        xm;
        logic signed [PRN_W:0] xs;
        for (int k = 0; k < 3; k++) begin
            x  = $signed({r_c_prn[k], 1'b0});
            xm = x[PRN_W] ? (PRN_W+1)'(-x) : (PRN_W+1)'(x);
            xs = x[PRN_W] ? -$signed(xm >> UNIT_FRAC_BITS) : $signed(xm >> UNIT_FRAC_BITS);
            n_d_r[k] = R_W'(xs) - R_W'(r_c_l[k]);
        end
    end

    // R.V, truncated toward zero.
    always_comb begin
        n_f_sum = SRV_W'(r_e_prv[0]) + SRV_W'(r_e_prv[1]) + SRV_W'(r_e_prv[2]);
        n_f_mag = n_f_sum[SRV_W-1] ? SRV_W'(-n_f_sum) : SRV_W'(n_f_sum);
        n_f_tr  = n_f_sum[SRV_W-1] ? -$signed(n_f_mag >> UNIT_FRAC_BITS)
                                   : $signed(n_f_mag >> UNIT_FRAC_BITS);
    end

    // Exponent limited to its range.
    always_comb begin
        if (i_cfg.specular_exponent == '0) begin
            exp_eff = EXP_W'(1);
        end else if (i_cfg.specular_exponent > EXP_W'(EXP_MAX)) begin
            exp_eff = EXP_W'(EXP_MAX);
        end else begin
            exp_eff = i_cfg.specular_exponent;
        end
    end

    // One multiply of the power per stage.
    always_comb begin
        logic [Q_W-1:0]   src_p;
        logic [Q_W-1:0]   src_sp;
        logic [2*Q_W-1:0] prod;
        for (int i = 0; i < POW_N; i++) begin
            if (i == 0) begin
                src_p  = r_f_sp;
                src_sp = r_f_sp;
            end else begin
                src_p  = r_p[i-1];
                src_sp = r_psp[i-1];
            end
            prod = (2*Q_W)'(src_p) * (2*Q_W)'(src_sp);
            if (EXP_W'(i + 1) < exp_eff) begin
                n_p[i] = Q_W'(prod >> UNIT_FRAC_BITS);
            end else begin
                n_p[i] = src_p;
            end
        end
    end

    // Diffuse and specular terms, and the final sum.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_t1_d[ch] = TP_W'(r_t0_d[ch]) * TP_W'(r_t0_dp);
            n_t1_s[ch] = TP_W'(r_t0_s[ch]) * TP_W'(r_t0_p);
            n_t2_sum[ch] = (CH_W+2)'(r_t1_a[ch]) + (CH_W+2)'(r_t1_d[ch])
                         + (CH_W+2)'(r_t1_s[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage A.
            for (int k = 0; k < 3; k++) begin
                r_a_pnl[k] <= i_n[k] * i_l[k];
            end
            r_a_n  <= i_n;
            r_a_l  <= i_l;
            r_a_v  <= i_v;
            r_a_nz <= i_nz;

            // Stage B.
            r_b_nl <= NL_W'(n_b_tr);
            if (!r_a_nz || n_b_tr <= 0) begin
                r_b_dp <= '0;
            end else if (n_b_tr > $signed(SNL_W'(UNIT_ONE))) begin
                r_b_dp <= UNIT_ONE;
            end else begin
                r_b_dp <= Q_W'(n_b_tr);
            end
            r_b_n  <= r_a_n;
            r_b_l  <= r_a_l;
            r_b_v  <= r_a_v;
            r_b_nz <= r_a_nz;

            // Stage C.
            for (int k = 0; k < 3; k++) begin
                r_c_prn[k] <= r_b_nl * r_b_n[k];
            end
            r_c_l  <= r_b_l;
            r_c_v  <= r_b_v;
            r_c_dp <= r_b_dp;
            r_c_nz <= r_b_nz;

            // Stage D.
            r_d_r  <= n_d_r;
            r_d_v  <= r_c_v;
            r_d_dp <= r_c_dp;
            r_d_nz <= r_c_nz;

            // Stage E.
            for (int k = 0; k < 3; k++) begin
                r_e_prv[k] <= r_d_r[k] * r_d_v[k];
            end
            r_e_dp <= r_d_dp;
            r_e_nz <= r_d_nz;

            // Stage F.
            if (!r_e_nz || n_f_tr <= 0) begin
                r_f_sp <= '0;
            end else if (n_f_tr > $signed(SRV_W'(UNIT_ONE))) begin
                r_f_sp <= UNIT_ONE;
            end else begin
                r_f_sp <= Q_W'(n_f_tr);
            end
            r_f_dp <= r_e_dp;

            // Power.
            for (int i = 0; i < POW_N; i++) begin
                r_p[i]   <= n_p[i];
                r_psp[i] <= (i == 0) ? r_f_sp : r_psp[i-1];
                r_pdp[i] <= (i == 0) ? r_f_dp : r_pdp[i-1];
            end

            // Color products.
            for (int ch = 0; ch < 3; ch++) begin
                r_t0_a[ch] <= CP_W'(i_cfg.ambient_color[CH_W*(2-ch) +: CH_W])
                            * CP_W'(i_cfg.ambient_reflect[CH_W*(2-ch) +: CH_W]);
                r_t0_d[ch] <= CP_W'(i_cfg.light_color[CH_W*(2-ch) +: CH_W])
                            * CP_W'(i_cfg.diffuse_reflect[CH_W*(2-ch) +: CH_W]);
                r_t0_s[ch] <= CP_W'(i_cfg.light_color[CH_W*(2-ch) +: CH_W])
                            * CP_W'(i_cfg.specular_reflect[CH_W*(2-ch) +: CH_W]);
            end
            r_t0_dp <= r_pdp[POW_N-1];
            r_t0_p  <= r_p[POW_N-1];

            // Terms, each truncated; the diffuse and specular terms are also clamped.
            for (int ch = 0; ch < 3; ch++) begin
                r_t1_a[ch] <= CH_W'(r_t0_a[ch] >> CH_W);
                if ((n_t1_d[ch] >> (CH_W + UNIT_FRAC_BITS)) > TP_W'(CH_MAX)) begin
                    r_t1_d[ch] <= CH_MAX;
                end else begin
                    r_t1_d[ch] <= CH_W'(n_t1_d[ch] >> (CH_W + UNIT_FRAC_BITS));
                end
                if ((n_t1_s[ch] >> (CH_W + UNIT_FRAC_BITS)) > TP_W'(CH_MAX)) begin
                    r_t1_s[ch] <= CH_MAX;
                end else begin
                    r_t1_s[ch] <= CH_W'(n_t1_s[ch] >> (CH_W + UNIT_FRAC_BITS));
                end
            end

            // Sum and clamp.
            for (int ch = 0; ch < 3; ch++) begin
                if (n_t2_sum[ch] > (CH_W+2)'(CH_MAX)) begin
                    r_rgb[2-ch] <= CH_MAX;
                end else begin
                    r_rgb[2-ch] <= CH_W'(n_t2_sum[ch]);
                end
            end
        end
    end

    assign o_rgb = r_rgb;

endmodule

// ===== rtl/phong_pixel_lighting.sv =====
// Phong lighting of a stream of surface normals with one directional light.
// i_norm carries one unnormalized normal per item (normal_x/y/z, signed 16-bit);
// o_rgb carries the lit color (out_red/green/blue, 8-bit) for each item, in order.
// Both channels use valid/ready; an item moves at a clock edge where both are high.
// Light color, light and view directions, ka/kd/ks and the specular exponent are
// written through i_cfg_we/i_cfg_idx/i_cfg_data; write them only while no item is
// in flight.
// Throughput: one item per clock while o_rgb is not stalled. From acceptance to
// the result at o_rgb an item passes the 24-stage square root and the 15-stage
// divider of the normalizers, then 24 stages of dot products, the power chain
// and the color terms. The light and view vectors are normalized in lockstep
// with each normal by their own copies of the normalizer.
// Reset clears the pipeline valid bits and sets every configuration register to
// zero except the specular exponent, which comes up as 4.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and i_norm.ready drops; nothing is lost or repeated. Bubbles in the
// pipeline are not squeezed out during a stall.
module phong_pixel_lighting import phl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    phl_in_if.sink                i_norm,
    phl_out_if.source             o_rgb,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  [TOT_LAT-1:0] r_vld;
    logic  adv;
    t_ivec nvec, lvec, vvec;
    t_uvec n_unit, l_unit, v_unit;
    logic  [NORM_LAT-1:0] r_nz;
    t_rgb  rgb;

    // Pipeline advances unless a finished result is held.
    assign adv          = !r_vld[TOT_LAT-1] || o_rgb.ready;
    assign i_norm.ready = adv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{specular_exponent: EXP_RESET, default: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AMBIENT_COLOR:   r_cfg.ambient_color     <= i_cfg_data[23:0];
                CFG_LIGHT_COLOR:     r_cfg.light_color       <= i_cfg_data[23:0];
                CFG_LIGHT_DIRECTION: r_cfg.light_direction   <= i_cfg_data[47:0];
                CFG_VIEW_DIRECTION:  r_cfg.view_direction    <= i_cfg_data[47:0];
                CFG_AMBIENT_REFLECT: r_cfg.ambient_reflect   <= i_cfg_data[23:0];
                CFG_DIFFUSE_REFLECT: r_cfg.diffuse_reflect   <= i_cfg_data[23:0];
                CFG_SPEC_REFLECT:    r_cfg.specular_reflect  <= i_cfg_data[23:0];
                CFG_SPEC_EXPONENT:   r_cfg.specular_exponent <= i_cfg_data[EXP_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[TOT_LAT-2:0], i_norm.valid};
        end
    end

    // Nonzero-normal flag delayed to meet the normalizer output.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nz <= {r_nz[NORM_LAT-2:0],
                     (i_norm.normal_x != '0) || (i_norm.normal_y != '0) ||
                     (i_norm.normal_z != '0)};
        end
    end

    // Unpack the vectors.
    always_comb begin
        nvec[0] = i_norm.normal_x;
        nvec[1] = i_norm.normal_y;
        nvec[2] = i_norm.normal_z;
        for (int k = 0; k < 3; k++) begin
            lvec[k] = $signed(r_cfg.light_direction[IN_W*(2-k) +: IN_W]);
            vvec[k] = $signed(r_cfg.view_direction[IN_W*(2-k) +: IN_W]);
        end
    end

    phl_norm u_norm_n (.i_clk(i_clk), .i_en(adv), .i_vec(nvec), .o_unit(n_unit));
    phl_norm u_norm_l (.i_clk(i_clk), .i_en(adv), .i_vec(lvec), .o_unit(l_unit));
    phl_norm u_norm_v (.i_clk(i_clk), .i_en(adv), .i_vec(vvec), .o_unit(v_unit));

    phl_shade u_shade (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_n   (n_unit),
        .i_l   (l_unit),
        .i_v   (v_unit),
        .i_nz  (r_nz[NORM_LAT-1]),
        .i_cfg (r_cfg),
        .o_rgb (rgb)
    );

    assign o_rgb.valid     = r_vld[TOT_LAT-1];
    assign o_rgb.out_red   = rgb[2];
    assign o_rgb.out_green = rgb[1];
    assign o_rgb.out_blue  = rgb[0];

endmodule

// ===== test/phong_pixel_lighting_test.sv =====
`timescale 1ns / 1ps

module phong_pixel_lighting_test;
    import phl_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = TOT_LAT + 20;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    // One row of the directed table: a normal and, where obvious, its color.
    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        bit          known;
        t_color      color;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    phl_in_if  norm_if ();
    phl_out_if rgb_if ();

    phong_pixel_lighting u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_norm     (norm_if.sink),
        .o_rgb      (rgb_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the lighting registers.
    logic [23:0] sh_amb_color;
    logic [23:0] sh_light_color;
    logic [47:0] sh_light_dir;
    logic [47:0] sh_view_dir;
    logic [23:0] sh_ka;
    logic [23:0] sh_kd;
    logic [23:0] sh_ks;
    logic [4:0]  sh_exp;

    t_color pending_colors[$];
    int     error_count;
    int     color_count;
    int     cycle_count;
    bit     rgb_ready_en;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Makes a vector unit length with 14 fraction bits.
    function automatic bit unit_vector(input longint v[3], output longint u[3]);
        longint m2;
        longint mag;
        longint q;
        longint root;
        longint rem;
        longint bitv;
        m2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        if (m2 == 0) begin
            u[0] = 0; u[1] = 0; u[2] = 0;
            return 0;
        end
        // Integer square root of m2 scaled by 2^16.
        rem = m2 << 16;
        root = 0;
        bitv = 64'sd1 << 60;
        while (bitv > rem) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >>> 1) + bitv;
            end else begin
                root = root >>> 1;
            end
            bitv = bitv >>> 2;
        end
        for (int k = 0; k < 3; k++) begin
            mag = v[k] < 0 ? -v[k] : v[k];
            q = (mag << (UNIT_FRAC_BITS + 8)) / root;
            if (q > (64'sd1 << UNIT_FRAC_BITS)) q = 64'sd1 << UNIT_FRAC_BITS;
            u[k] = v[k] < 0 ? -q : q;
        end
        return 1;
    endfunction

    function automatic longint trunc_frac(input longint x);
        return x < 0 ? -((-x) >>> UNIT_FRAC_BITS) : (x >>> UNIT_FRAC_BITS);
    endfunction

    function automatic longint clamp_one(input longint x);
        if (x < 0) return 0;
        return x > (64'sd1 << UNIT_FRAC_BITS) ? (64'sd1 << UNIT_FRAC_BITS) : x;
    endfunction

    function automatic longint sat8(input longint x);
        return x > 255 ? 255 : x;
    endfunction

    // Predicts the lit color of one normal under the current registers.
    function automatic t_color shade_normal(input logic [15:0] nx, ny, nz);
        longint nv[3], lv[3], vv[3], n[3], l[3], v[3], r[3];
        longint nl, dp, sp, pw, a, d, s, ac, lc, ka, kd, ks;
        int e;
        int sh;
        bit has_n;
        longint sum[3];
        t_color c;
        nv[0] = longint'($signed(nx));
        nv[1] = longint'($signed(ny));
        nv[2] = longint'($signed(nz));
        lv[0] = longint'($signed(sh_light_dir[47:32]));
        lv[1] = longint'($signed(sh_light_dir[31:16]));
        lv[2] = longint'($signed(sh_light_dir[15:0]));
        vv[0] = longint'($signed(sh_view_dir[47:32]));
        vv[1] = longint'($signed(sh_view_dir[31:16]));
        vv[2] = longint'($signed(sh_view_dir[15:0]));
        has_n = unit_vector(nv, n);
        void'(unit_vector(lv, l));
        void'(unit_vector(vv, v));
        e = sh_exp;
        if (e < 1) e = 1;
        if (e > EXP_MAX) e = EXP_MAX;
        dp = 0; sp = 0; pw = 0;
        if (has_n) begin
            nl = trunc_frac(n[0] * l[0] + n[1] * l[1] + n[2] * l[2]);
            dp = clamp_one(nl);
            for (int k = 0; k < 3; k++) r[k] = trunc_frac(2 * nl * n[k]) - l[k];
            sp = clamp_one(trunc_frac(r[0] * v[0] + r[1] * v[1] + r[2] * v[2]));
            pw = sp;
            for (int k = 1; k < e; k++) pw = (pw * sp) >>> UNIT_FRAC_BITS;
        end
        for (int ch = 0; ch < 3; ch++) begin
            sh = 16 - 8 * ch;
            ac = (sh_amb_color >> sh) & 8'hFF;
            lc = (sh_light_color >> sh) & 8'hFF;
            ka = (sh_ka >> sh) & 8'hFF;
            kd = (sh_kd >> sh) & 8'hFF;
            ks = (sh_ks >> sh) & 8'hFF;
            a = sat8((ac * ka) >>> 8);
            d = sat8((lc * kd * dp) >>> (8 + UNIT_FRAC_BITS));
            s = sat8((lc * ks * pw) >>> (8 + UNIT_FRAC_BITS));
            sum[ch] = sat8(a + d + s);
        end
        c.red = sum[0][7:0];
        c.green = sum[1][7:0];
        c.blue = sum[2][7:0];
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on color %0d: %s got %0d, expected %0d",
                 color_count, what, got, want);
        error_count++;
    endtask

    // Receiver: stalls on its own pattern and checks every accepted color.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            rgb_if.ready <= rgb_ready_en ? 1'b1 : (($urandom % 5) != 0);
        end
        if (i_rst_n && rgb_if.valid && rgb_if.ready) begin
            if (pending_colors.size() == 0) begin
                $display("unexpected color %0d", color_count);
                error_count++;
            end else begin
                t_color want;
                want = pending_colors.pop_front();
                if (rgb_if.out_red !== want.red)
                    report_mismatch("red", rgb_if.out_red, want.red);
                if (rgb_if.out_green !== want.green)
                    report_mismatch("green", rgb_if.out_green, want.green);
                if (rgb_if.out_blue !== want.blue)
                    report_mismatch("blue", rgb_if.out_blue, want.blue);
            end
            color_count++;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_AMBIENT_COLOR:   sh_amb_color = data[23:0];
            CFG_LIGHT_COLOR:     sh_light_color = data[23:0];
            CFG_LIGHT_DIRECTION: sh_light_dir = data;
            CFG_VIEW_DIRECTION:  sh_view_dir = data;
            CFG_AMBIENT_REFLECT: sh_ka = data[23:0];
            CFG_DIFFUSE_REFLECT: sh_kd = data[23:0];
            CFG_SPEC_REFLECT:    sh_ks = data[23:0];
            default:             sh_exp = data[4:0];
        endcase
    endtask

    // Waits until every predicted color has arrived and the pipeline is empty.
    task automatic drain_pipeline();
        norm_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sends one normal; the expectation is queued when it is accepted.
    task automatic send_normal(input logic [15:0] nx, ny, nz,
                               input bit known, input t_color fixed);
        t_color want;
        want = shade_normal(nx, ny, nz);
        if (known && want != fixed) begin
            $display("table row disagrees with the lighting model");
            error_count++;
        end
        norm_if.valid <= 1'b1;
        norm_if.normal_x <= nx;
        norm_if.normal_y <= ny;
        norm_if.normal_z <= nz;
        @(posedge i_clk);
        while (!norm_if.ready) @(posedge i_clk);
        pending_colors.push_back(known ? fixed : want);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom % 6)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_dir();
        return {rand_comp(), rand_comp(), rand_comp()};
    endfunction

    // Random lighting setup; extremes show up now and then.
    task automatic random_setup();
        write_reg(CFG_AMBIENT_COLOR, ($urandom % 4 == 0) ? 48'hFFFFFF : 48'($urandom));
        write_reg(CFG_LIGHT_COLOR, ($urandom % 4 == 0) ? 48'hFFFFFF : 48'($urandom));
        write_reg(CFG_LIGHT_DIRECTION, ($urandom % 8 == 0) ? 48'h0 : rand_dir());
        write_reg(CFG_VIEW_DIRECTION, ($urandom % 8 == 0) ? 48'h0 : rand_dir());
        write_reg(CFG_AMBIENT_REFLECT, 48'($urandom));
        write_reg(CFG_DIFFUSE_REFLECT, ($urandom % 4 == 0) ? 48'hFFFFFF : 48'($urandom));
        write_reg(CFG_SPEC_REFLECT, ($urandom % 4 == 0) ? 48'hFFFFFF : 48'($urandom));
        write_reg(CFG_SPEC_EXPONENT, 48'($urandom_range(0, 31)));
    endtask

    t_row directed_rows[$];
    t_color none;
    int burst;

    initial begin
        error_count = 0;
        color_count = 0;
        cycle_count = 0;
        rgb_ready_en = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        norm_if.valid = 1'b0;
        norm_if.normal_x = '0;
        norm_if.normal_y = '0;
        norm_if.normal_z = '0;
        rgb_if.ready = 1'b0;
        none = '{8'd0, 8'd0, 8'd0};
        sh_amb_color = '0; sh_light_color = '0; sh_light_dir = '0; sh_view_dir = '0;
        sh_ka = '0; sh_kd = '0; sh_ks = '0; sh_exp = EXP_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset every register but the exponent is zero, so every normal is black.
        send_normal(16'h7FFF, 16'h8000, 16'h0001, 1, none);
        send_normal(16'h0000, 16'h0000, 16'h0000, 1, none);
        drain_pipeline();

        // White light head-on, with partial reflectances.
        write_reg(CFG_AMBIENT_COLOR, 48'hFFFFFF);
        write_reg(CFG_LIGHT_COLOR, 48'hFFFFFF);
        write_reg(CFG_LIGHT_DIRECTION, {16'd0, 16'd0, 16'd1000});
        write_reg(CFG_VIEW_DIRECTION, {16'd0, 16'd0, 16'd1000});
        write_reg(CFG_AMBIENT_REFLECT, 48'h200000);
        write_reg(CFG_DIFFUSE_REFLECT, 48'h804020);
        write_reg(CFG_SPEC_REFLECT, 48'h101010);
        write_reg(CFG_SPEC_EXPONENT, 48'd16);
        // A zero normal gives ambient only: 255*32/256 = 31 in red.
        directed_rows = '{
            '{16'h0000, 16'h0000, 16'h0000, 1, '{8'd31, 8'd0, 8'd0}},
            '{16'h0000, 16'h0000, 16'h7FFF, 0, none},
            '{16'h0000, 16'h0000, 16'h8000, 0, none},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, none},
            '{16'h8000, 16'h8000, 16'h8000, 0, none},
            '{16'h0001, 16'h0000, 16'h0000, 0, none},
            '{16'h0000, 16'hFFFF, 16'h0001, 0, none},
            '{16'h1234, 16'hEDCB, 16'h4000, 0, none},
            '{16'h0000, 16'h0000, 16'h0001, 0, none}
        };
        foreach (directed_rows[i])
            send_normal(directed_rows[i].nx, directed_rows[i].ny, directed_rows[i].nz,
                        directed_rows[i].known, directed_rows[i].color);
        drain_pipeline();

        // Zero light direction, zero view direction, exponent zero and exponent 31.
        write_reg(CFG_LIGHT_DIRECTION, 48'h0);
        write_reg(CFG_SPEC_EXPONENT, 48'd0);
        send_normal(16'h0000, 16'h0000, 16'h7FFF, 1, '{8'd31, 8'd0, 8'd0});
        drain_pipeline();
        write_reg(CFG_LIGHT_DIRECTION, {16'h8000, 16'h7FFF, 16'h0001});
        write_reg(CFG_VIEW_DIRECTION, 48'h0);
        write_reg(CFG_SPEC_EXPONENT, 48'd31);
        send_normal(16'h8000, 16'h7FFF, 16'h0001, 0, none);
        send_normal(16'h0100, 16'h0200, 16'hFF00, 0, none);
        drain_pipeline();
        write_reg(CFG_SPEC_EXPONENT, 48'd1);

        // Random phases: bursty sender, stalling receiver.
        for (int ph = 0; ph < 10; ph++) begin
            random_setup();
            rgb_ready_en = (ph == 3);
            for (int n = 0; n < RANDOM_ITEMS / 10; n++) begin
                if (n % 37 == 0) begin
                    burst = $urandom_range(1, 24);
                    if (ph % 2 == 0) begin
                        norm_if.valid <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge i_clk);
                    end
                end
                if (n == 80 && ph == 5) begin
                    norm_if.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_colors.size() != 0) @(posedge i_clk);
                end
                if (--burst <= 0 && ph != 3) begin
                    burst = $urandom_range(1, 24);
                    norm_if.valid <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge i_clk);
                end
                send_normal(rand_comp(), rand_comp(), rand_comp(), 0, none);
            end
            drain_pipeline();
        end

        $display("covered %0d colors over reset, directed and 10 random lighting setups",
                 color_count);
        $display("including zero vectors, exponent limits and full-scale components");
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/phl_pkg.sv
rtl/phl_in_if.sv
rtl/phl_out_if.sv
rtl/phl_norm.sv
rtl/phl_shade.sv
rtl/phong_pixel_lighting.sv
test/phong_pixel_lighting_test.sv
